### hdl/ndpa_pkg.sv
// ----------------------------------------------------------------------------
// ndpa_pkg: shared types and constants for the node distance and angle unit
// Item structs, CORDIC arctangent table and fixed-point constants.
// ----------------------------------------------------------------------------
package ndpa_pkg;

   localparam int NodesDefault = 1024;
   localparam int IndexWidth   = 10;
   localparam int CordicSteps  = 30;
   localparam int AngleWidth   = 16;
   localparam int DistWidth    = 25;
   localparam int SqWidth      = 50;   // (dx^2+dy^2) << 16
   localparam int RootWidth    = 25;
   localparam int CordicWidth  = 40;   // 17-bit diff << 20, plus growth
   localparam int ZWidth       = 34;

   localparam logic signed [ZWidth-1:0] PiQ30      = 34'sd3373259426;
   localparam logic signed [15:0]       AnglePi    = 16'sd25736;
   localparam logic signed [15:0]       AngleHalfPi = 16'sd12868;

   typedef enum logic [0:0] {
      CMD_STORE = 1'b0,
      CMD_QUERY = 1'b1
   } cmd_type;

   typedef struct packed {
      cmd_type                cmd;
      logic [IndexWidth-1:0]  store_index;
      logic signed [15:0]     store_x;
      logic signed [15:0]     store_y;
      logic [IndexWidth-1:0]  from_node;
      logic [IndexWidth-1:0]  to_node;
   } req_type;

   typedef struct packed {
      logic [DistWidth-1:0]         distance;
      logic signed [AngleWidth-1:0] angle;
   } rsp_type;

   // axis and zero handling decided before the CORDIC, carried alongside
   typedef struct packed {
      logic                         bypass;
      logic signed [AngleWidth-1:0] fixed_angle;
   } axis_type;

   function automatic logic [ZWidth-1:0] atan_q30(input int i);
      logic [ZWidth-1:0] t;
      unique case (i)
         0: t = 34'h03243F6A8;  1: t = 34'h01DAC6705;  2: t = 34'h00FADBAFC;
         3: t = 34'h007F56EA6;  4: t = 34'h003FEAB76;  5: t = 34'h001FFD55B;
         6: t = 34'h000FFFAAA;  7: t = 34'h0007FFF55;  8: t = 34'h0003FFFEA;
         9: t = 34'h0001FFFFD; 10: t = 34'h0000FFFFF; 11: t = 34'h00007FFFF;
        12: t = 34'h00003FFFF; 13: t = 34'h00001FFFF; 14: t = 34'h00000FFFF;
        15: t = 34'h000007FFF; 16: t = 34'h000003FFF; 17: t = 34'h000001FFF;
        18: t = 34'h000000FFF; 19: t = 34'h0000007FF; 20: t = 34'h0000003FF;
        21: t = 34'h0000001FF; 22: t = 34'h0000000FF; 23: t = 34'h00000007F;
        24: t = 34'h00000003F; 25: t = 34'h00000001F; 26: t = 34'h00000000F;
        27: t = 34'h000000007; 28: t = 34'h000000003; 29: t = 34'h000000001;
        default: t = '0;
      endcase
      return t;
   endfunction

endpackage

### hdl/ndpa_sqrt_pipe.sv
// ----------------------------------------------------------------------------
// ndpa_sqrt_pipe: pipelined rounded integer square root
// One result bit per stage, restoring method, rounding in the last stage.
// ----------------------------------------------------------------------------
module ndpa_sqrt_pipe (
   input  logic                          clock,
   input  logic [ndpa_pkg::SqWidth-1:0]   radicand,
   output logic [ndpa_pkg::RootWidth-1:0] root
);
   import ndpa_pkg::*;

   localparam int Steps = RootWidth;
   localparam int RemW  = RootWidth + 2;

   logic [SqWidth-1:0]   val_ff [Steps+1];
   logic [RootWidth-1:0] q_ff   [Steps+1];
   logic [RemW-1:0]      rem_ff [Steps+1];
   logic [RootWidth-1:0] root_ff;

   always_comb begin
      val_ff[0] = radicand;
      q_ff[0]   = '0;
      rem_ff[0] = '0;
   end

   for (genvar s = 0; s < Steps; s++) begin : g_step
      logic [RemW-1:0]      rem_in;
      logic [RemW-1:0]      trial_in;
      logic [RootWidth-1:0] q_in;
      logic [RemW-1:0]      rem_next_in;
      always_comb begin
         rem_in   = {rem_ff[s][RemW-3:0], val_ff[s][SqWidth-1-2*s -: 2]};
         trial_in = {q_ff[s], 2'b01};
         if (rem_in >= trial_in) begin
            rem_next_in = rem_in - trial_in;
            q_in        = {q_ff[s][RootWidth-2:0], 1'b1};
         end else begin
            rem_next_in = rem_in;
            q_in        = {q_ff[s][RootWidth-2:0], 1'b0};
         end
      end
      always_ff @(posedge clock) begin
         val_ff[s+1] <= val_ff[s];
         q_ff[s+1]   <= q_in;
         rem_ff[s+1] <= rem_next_in;
      end
   end

   // round up when remainder exceeds the root
   always_ff @(posedge clock) begin
      if (rem_ff[Steps] > {2'b00, q_ff[Steps]}) begin
         root_ff <= q_ff[Steps] + 1'b1;
      end else begin
         root_ff <= q_ff[Steps];
      end
   end

   assign root = root_ff;

endmodule

### hdl/ndpa_cordic_pipe.sv
// ----------------------------------------------------------------------------
// ndpa_cordic_pipe: pipelined vectoring CORDIC for atan2
// One micro-rotation per stage, then rounding and clamping to Q3.13, or the axis angle on bypass.
// ----------------------------------------------------------------------------
module ndpa_cordic_pipe (
   input  logic                                  clock,
   input  logic signed [16:0]                    dx,
   input  logic signed [16:0]                    dy,
   input  ndpa_pkg::axis_type                    axis,
   output logic signed [ndpa_pkg::AngleWidth-1:0] angle
);
   import ndpa_pkg::*;

   localparam int W = CordicWidth;

   logic signed [W-1:0]      x_ff [CordicSteps+1];
   logic signed [W-1:0]      y_ff [CordicSteps+1];
   logic signed [ZWidth-1:0] z_ff [CordicSteps+1];
   axis_type                 ax_ff [CordicSteps+1];
   logic signed [AngleWidth-1:0] angle_ff;

   // pre-rotation into the right half plane
   logic signed [W-1:0] x0, y0;
   always_comb begin
      x0 = W'(dx) <<< 20;
      y0 = W'(dy) <<< 20;
      if (dx < 0) begin
         x_ff[0] = -x0;
         y_ff[0] = -y0;
         z_ff[0] = (dy >= 0) ? PiQ30 : -PiQ30;
      end else begin
         x_ff[0] = x0;
         y_ff[0] = y0;
         z_ff[0] = '0;
      end
      ax_ff[0] = axis;
   end

   for (genvar i = 0; i < CordicSteps; i++) begin : g_rot
      localparam logic signed [ZWidth-1:0] Atan = atan_q30(i);
      always_ff @(posedge clock) begin
         ax_ff[i+1] <= ax_ff[i];
         if (!y_ff[i][W-1]) begin
            x_ff[i+1] <= x_ff[i] + (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] - (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] + Atan;
         end else begin
            x_ff[i+1] <= x_ff[i] - (y_ff[i] >>> i);
            y_ff[i+1] <= y_ff[i] + (x_ff[i] >>> i);
            z_ff[i+1] <= z_ff[i] - Atan;
         end
      end
   end

   logic signed [ZWidth-1:0] zr;
   logic signed [ZWidth-18:0] q;
   always_comb begin
      zr = z_ff[CordicSteps] + ZWidth'(65536);
      q  = zr[ZWidth-1:17];
   end

   always_ff @(posedge clock) begin
      if (ax_ff[CordicSteps].bypass) begin
         angle_ff <= ax_ff[CordicSteps].fixed_angle;
      end else if (q > 17'(AnglePi)) begin
         angle_ff <= AnglePi;
      end else if (q < -17'(AnglePi)) begin
         angle_ff <= -AnglePi;
      end else begin
         angle_ff <= q[AngleWidth-1:0];
      end
   end

   assign angle = angle_ff;

endmodule

### hdl/node_distance_and_polar_angle_unit.sv
// ----------------------------------------------------------------------------
// node_distance_and_polar_angle_unit: node table with distance and atan2
// Stores 2-D node coordinates and answers distance/angle queries.
// ----------------------------------------------------------------------------
// Usage:
//   Drive req_item with start high; the item is taken on any edge with busy
//   low. busy is tied low: the unit takes one item every cycle.
//   A store item (cmd = store) writes a node slot and gives no result.
//   A query item reads two slots and gives one result on rsp_item, marked by
//   rsp_valid for exactly one cycle; the receiver cannot stall it.
//   A query passes the table read, the differences, 30 CORDIC stages and
//   angle rounding, then the result register. The distance path (squares,
//   sum, square root 25 + rounding) is three stages shorter and is
//   delayed to match.
//   Throughput: one item per cycle, set by the fully pipelined root and
//   CORDIC stages; the table is a memory with one write and two read ports.
//   Results leave in query order. A store that precedes a query is visible
//   to it, since the store writes the table on acceptance, before the query's read.
//   Reset clears the valid bits of the pipeline; the node table is not
//   cleared and slots read before being written give undefined values.
// ----------------------------------------------------------------------------
module node_distance_and_polar_angle_unit #(
   parameter int NODES = ndpa_pkg::NodesDefault
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              start,
   output logic              busy,
   input  ndpa_pkg::req_type req_item,
   output logic              rsp_valid,
   output ndpa_pkg::rsp_type rsp_item
);
   import ndpa_pkg::*;

   localparam int AddrW    = (NODES > 1) ? $clog2(NODES) : 1;
   localparam int SqrtLat  = RootWidth + 1;
   localparam int CordLat  = CordicSteps + 1;
   // depths from the difference register to the root and angle outputs
   localparam int DistPath = 2 + SqrtLat;
   localparam int AngPath  = CordLat;
   localparam int Lat      = 1 + 1 + AngPath; // valid depth from acceptance

   logic signed [15:0] mem_x [NODES];
   logic signed [15:0] mem_y [NODES];

   logic accept;
   assign busy   = 1'b0;
   assign accept = start && !busy;

   // store port: drop writes beyond the table
   always_ff @(posedge clock) begin
      if (accept && req_item.cmd == CMD_STORE &&
          32'(req_item.store_index) < NODES) begin
         mem_x[AddrW'(req_item.store_index)] <= req_item.store_x;
         mem_y[AddrW'(req_item.store_index)] <= req_item.store_y;
      end
   end

   // stage 1: table read, out-of-range slots read as zero
   logic signed [15:0] ax_ff, ay_ff, bx_ff, by_ff;
   logic               ina_ff, inb_ff;
   always_ff @(posedge clock) begin
      ax_ff  <= mem_x[AddrW'(req_item.from_node)];
      ay_ff  <= mem_y[AddrW'(req_item.from_node)];
      bx_ff  <= mem_x[AddrW'(req_item.to_node)];
      by_ff  <= mem_y[AddrW'(req_item.to_node)];
      ina_ff <= 32'(req_item.from_node) < NODES;
      inb_ff <= 32'(req_item.to_node) < NODES;
   end

   // stage 2: differences and axis cases
   logic signed [16:0] dx_ff, dy_ff;
   axis_type           axis_ff;
   logic signed [16:0] dx_in, dy_in;
   axis_type           axis_in;
   always_comb begin
      dx_in = (inb_ff ? 17'(bx_ff) : 17'sd0) - (ina_ff ? 17'(ax_ff) : 17'sd0);
      dy_in = (inb_ff ? 17'(by_ff) : 17'sd0) - (ina_ff ? 17'(ay_ff) : 17'sd0);
      axis_in.bypass      = (dx_in == '0) || (dy_in == '0);
      axis_in.fixed_angle = '0;
      if (dy_in == '0) begin
         axis_in.fixed_angle = (dx_in < 0) ? AnglePi : '0;
      end else if (dx_in == '0) begin
         axis_in.fixed_angle = (dy_in > 0) ? AngleHalfPi : -AngleHalfPi;
      end
   end
   always_ff @(posedge clock) begin
      dx_ff   <= dx_in;
      dy_ff   <= dy_in;
      axis_ff <= axis_in;
   end

   // distance path: squares, sum, root
   logic [33:0] sqx_ff, sqy_ff;
   logic [SqWidth-1:0] sum_ff;
   logic [RootWidth-1:0] root;
   always_ff @(posedge clock) begin
      sqx_ff <= 34'(dx_ff * dx_ff);
      sqy_ff <= 34'(dy_ff * dy_ff);
      sum_ff <= SqWidth'({sqx_ff + sqy_ff, 16'd0});
   end

   ndpa_sqrt_pipe u_sqrt (
      .clock    (clock),
      .radicand (sum_ff),
      .root     (root)
   );

   // angle path; the root is delayed to line up with it
   logic signed [AngleWidth-1:0] angle;
   logic [RootWidth-1:0] rdly_ff [AngPath-DistPath+1];
   ndpa_cordic_pipe u_cordic (
      .clock (clock),
      .dx    (dx_ff),
      .dy    (dy_ff),
      .axis  (axis_ff),
      .angle (angle)
   );
   always_comb rdly_ff[0] = root;
   for (genvar d = 0; d < AngPath - DistPath; d++) begin : g_rdly
      always_ff @(posedge clock) rdly_ff[d+1] <= rdly_ff[d];
   end

   // valid bits travel alongside
   logic [Lat-1:0] vld_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else begin
         vld_ff <= {vld_ff[Lat-2:0], accept && req_item.cmd == CMD_QUERY};
      end
   end

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_ff;
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= vld_ff[Lat-1];
      end
      rsp_ff.distance <= rdly_ff[AngPath-DistPath];
      rsp_ff.angle    <= angle;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_item  = rsp_ff;

endmodule

### hdl/ndpa_checker.sv
// ----------------------------------------------------------------------------
// ndpa_checker: port-level checks for the node distance and angle unit
// Watches the result strobe and payload ranges against the port activity.
// ----------------------------------------------------------------------------
module ndpa_checker (
   input logic              clock,
   input logic              reset,
   input logic              busy,
   input logic              rsp_valid,
   input ndpa_pkg::rsp_type rsp_item
);
   import ndpa_pkg::*;

   // the unit never refuses an item
   a_never_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   // no result right after reset
   a_quiet_after_reset: assert property (@(posedge clock) reset |=> !rsp_valid)
      else $error("result after reset");

   // angle stays within plus or minus pi
   a_angle_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_item.angle <= AnglePi && rsp_item.angle >= -AnglePi))
      else $error("angle out of range");

   // zero distance means coincident points and angle zero
   a_zero_dist: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_item.distance == '0) |-> rsp_item.angle == '0)
      else $error("zero distance with nonzero angle");

endmodule

bind node_distance_and_polar_angle_unit ndpa_checker u_ndpa_checker (
   .clock     (clock),
   .reset     (reset),
   .busy      (busy),
   .rsp_valid (rsp_valid),
   .rsp_item  (rsp_item)
);

### tb/sv/node_distance_and_polar_angle_unit_test.sv
// ----------------------------------------------------------------------------
// node_distance_and_polar_angle_unit_test: self-checking bench for the unit
// Stores node coordinates and queries them, predicting distance and angle
// with a local square root and CORDIC, and compares every result in order.
// ----------------------------------------------------------------------------
module node_distance_and_polar_angle_unit_test;
   timeunit 1ns;
   timeprecision 1ps;
   import ndpa_pkg::*;

   localparam int Latency = 35;
   localparam int ReqBits = $bits(req_type);

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    start = 1'b0;
   logic    busy;
   req_type req_item = '0;
   logic    rsp_valid;
   rsp_type rsp_item;

   node_distance_and_polar_angle_unit i_dut (
      .clock(clock), .reset(reset), .start(start), .busy(busy),
      .req_item(req_item), .rsp_valid(rsp_valid), .rsp_item(rsp_item)
   );

   always #6 clock = ~clock;

   // pending items for the driver, predicted results for the monitor
   req_type pending_items[$];
   rsp_type expected_polar[$];
   // shadow copy of the node table, plus which slots have been written
   logic [31:0] node_shadow [1024];
   bit          node_written [1024];
   bit          idle_free = 1'b0;
   int          mismatches = 0;

   // arctangent of 2^-i in radians scaled by 2^30, truncated
   function automatic longint atan_step(input int i);
      longint tab [30] = '{
         64'h3243F6A8, 64'h1DAC6705, 64'h0FADBAFC, 64'h07F56EA6, 64'h03FEAB76,
         64'h01FFD55B, 64'h00FFFAAA, 64'h007FFF55, 64'h003FFFEA, 64'h001FFFFD,
         64'h000FFFFF, 64'h0007FFFF, 64'h0003FFFF, 64'h0001FFFF, 64'h0000FFFF,
         64'h00007FFF, 64'h00003FFF, 64'h00001FFF, 64'h00000FFF, 64'h000007FF,
         64'h000003FF, 64'h000001FF, 64'h000000FF, 64'h0000007F, 64'h0000003F,
         64'h0000001F, 64'h0000000F, 64'h00000007, 64'h00000003, 64'h00000001};
      return tab[i];
   endfunction

   // nearest integer square root, halves rounded up
   function automatic longint unsigned round_root(input longint unsigned v);
      longint unsigned r = 0, rem = v, b = 64'd1 << 62;
      while (b > rem) b >>= 2;
      while (b != 0) begin
         if (rem >= r + b) begin
            rem = rem - (r + b);
            r = (r >> 1) + b;
         end else begin
            r >>= 1;
         end
         b >>= 2;
      end
      if (rem > r) r++;
      return r;
   endfunction

   // atan2(dy, dx) in Q3.13 by vectoring CORDIC; >>> on longint floors
   function automatic logic signed [15:0] polar_angle(input int dx, input int dy);
      longint x, y, z, nx, ny, q;
      z = 0;
      if (dy == 0) return (dx < 0) ? AnglePi : 16'sd0;
      if (dx == 0) return (dy > 0) ? AngleHalfPi : -AngleHalfPi;
      x = longint'(dx) <<< 20;
      y = longint'(dy) <<< 20;
      if (x < 0) begin
         z = (y >= 0) ? 64'sd3373259426 : -64'sd3373259426;
         x = -x;
         y = -y;
      end
      for (int i = 0; i < 30; i++) begin
         if (y >= 0) begin
            nx = x + (y >>> i); ny = y - (x >>> i); z += atan_step(i);
         end else begin
            nx = x - (y >>> i); ny = y + (x >>> i); z -= atan_step(i);
         end
         x = nx; y = ny;
      end
      q = (z + (64'sd1 <<< 16)) >>> 17;
      if (q > 25736) q = 25736;
      if (q < -25736) q = -25736;
      return 16'(q);
   endfunction

   // update the shadow table or work out the expected result of a query
   function automatic void predict_polar(input req_type it);
      int dx, dy;
      logic [31:0] a, b;
      longint unsigned sq;
      rsp_type r;
      if (it.cmd == CMD_STORE) begin
         node_shadow[it.store_index] = {it.store_y, it.store_x};
         node_written[it.store_index] = 1'b1;
         return;
      end
      a = node_shadow[it.from_node];
      b = node_shadow[it.to_node];
      dx = int'($signed(b[15:0])) - int'($signed(a[15:0]));
      dy = int'($signed(b[31:16])) - int'($signed(a[31:16]));
      sq = longint'(dx) * dx + longint'(dy) * dy;
      r.distance = DistWidth'(round_root(sq << 16));
      r.angle = polar_angle(dx, dy);
      expected_polar.push_back(r);
   endfunction

   function automatic req_type store_item(input int idx, input int x, input int y);
      req_type it = '0;
      it.cmd = CMD_STORE;
      it.store_index = idx[9:0];
      it.store_x = x[15:0];
      it.store_y = y[15:0];
      return it;
   endfunction

   function automatic req_type query_item(input int f, input int t);
      req_type it = '0;
      it.cmd = CMD_QUERY;
      it.from_node = f[9:0];
      it.to_node = t[9:0];
      return it;
   endfunction

   // pick a slot already written, so no query reads undefined data
   function automatic int written_slot();
      int s;
      do s = $urandom_range(1023); while (!node_written[s]);
      return s;
   endfunction

   // Driver: present the head item; advance on every accepting edge
   always @(posedge clock) begin
      if (reset) begin
         start <= 1'b0;
      end else begin
         if (start && !busy) begin
            predict_polar(req_item);
            void'(pending_items.pop_front());
         end
         // idle in about a quarter of cycles, except in the burst stretch
         if (pending_items.size() > (start && !busy ? 0 : 0) &&
             pending_items.size() != 0 && (idle_free || $urandom_range(99) >= 26)) begin
            start <= 1'b1;
            req_item <= pending_items[0];
         end else begin
            start <= 1'b0;
            // randomise unused fields so idle cycles carry noise
            req_item <= req_type'(ReqBits'({$urandom, $urandom}));
         end
      end
   end

   // Monitor: every strobed result must match the oldest prediction
   always @(posedge clock) begin
      if (!reset && rsp_valid) begin
         if (expected_polar.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: distance %0d angle %0d",
                        rsp_item.distance, rsp_item.angle);
         end else begin
            rsp_type e;
            e = expected_polar.pop_front();
            if (e.distance !== rsp_item.distance || e.angle !== rsp_item.angle) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Mismatch: expected distance %0d angle %0d, got %0d %0d",
                           e.distance, e.angle, rsp_item.distance, rsp_item.angle);
            end
         end
      end
   end

   initial begin
      int n, ext [6];
      ext = '{-32768, 32767, 0, -1, 1, 12345};
      // directed: extreme corners, equal points, both axes, all quadrants
      pending_items.push_back(store_item(0, -32768, -32768));
      pending_items.push_back(store_item(1023, 32767, 32767));
      pending_items.push_back(store_item(1, 32767, -32768));
      pending_items.push_back(store_item(2, -32768, 32767));
      pending_items.push_back(store_item(3, 0, 0));
      pending_items.push_back(store_item(4, 100, 0));
      pending_items.push_back(store_item(5, 0, 100));
      pending_items.push_back(query_item(0, 1023));
      pending_items.push_back(query_item(1023, 0));
      pending_items.push_back(query_item(1, 2));
      pending_items.push_back(query_item(2, 1));
      pending_items.push_back(query_item(3, 3));
      pending_items.push_back(query_item(3, 4));
      pending_items.push_back(query_item(4, 3));
      pending_items.push_back(query_item(3, 5));
      pending_items.push_back(query_item(5, 3));
      pending_items.push_back(query_item(4, 5));
      pending_items.push_back(query_item(0, 1));
      pending_items.push_back(query_item(1, 0));
      // store then query straight after, to check write-to-read visibility
      pending_items.push_back(store_item(6, -7, 9));
      pending_items.push_back(query_item(6, 3));
      // shadow-track which slots the queued stores will fill
      foreach (node_written[i]) node_written[i] = 1'b0;
      foreach (pending_items[i])
         if (pending_items[i].cmd == CMD_STORE)
            node_written[pending_items[i].store_index] = 1'b1;
      // random: mostly queries over written slots, some fresh stores
      for (int k = 0; k < 800; k++) begin
         if ($urandom_range(99) < 30) begin
            n = $urandom_range(3);
            pending_items.push_back(store_item($urandom_range(1023),
               n == 0 ? ext[$urandom_range(5)] : int'($urandom),
               n == 1 ? ext[$urandom_range(5)] : int'($urandom)));
            node_written[pending_items[$].store_index] = 1'b1;
         end else begin
            pending_items.push_back(query_item(written_slot(), written_slot()));
         end
      end
      // the driver rebuilds the written flags from accepted stores
      foreach (node_written[i]) node_written[i] = 1'b0;
      foreach (node_shadow[i]) node_shadow[i] = '0;
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      // hold a burst with no idling in the middle of the run
      wait (pending_items.size() < 500);
      idle_free = 1'b1;
      wait (pending_items.size() < 300);
      idle_free = 1'b0;
      wait (pending_items.size() == 0);
      wait (expected_polar.size() == 0);
      repeat (Latency + 10) @(posedge clock);
      if (mismatches == 0 && expected_polar.size() == 0) begin
         $display("Verification passed");
      end else begin
         $display("Verification failed");
      end
      $finish;
   end

   initial begin
      #2000000;
      $display("Verification failed");
      $finish;
   end

endmodule
